// ===== src/tkns_pkg.sv =====
// tkns_pkg: shared types, sizes and codes for the top-k nearest selector
// no dependencies; used by tkns_cell and top_k_nearest_selector_unit

package tkns_pkg;

	// number of cells in the sorted chain
	localparam int CAPACITY = 16;
	// most results one finish can emit
	localparam int MAX_EMIT = 16;
	// largest usable k
	localparam int KMAX = (CAPACITY < MAX_EMIT) ? CAPACITY : MAX_EMIT;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int KCNT_W = $clog2(KMAX + 1);
	localparam int DIST_W = 32;
	localparam int ID_W   = 32;
	localparam int RANK_W = 4;
	localparam int KREG_W = 5;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [KCNT_W-1:0] kcnt_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [ID_W-1:0]   id_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [KREG_W-1:0] kreg_t;

	// command codes
	localparam logic CMD_OFFER  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// control broadcast to every cell
	typedef struct packed {
		logic insert;  // offer request taken this cycle
		logic shift;   // move every entry one cell toward the head
		logic full;    // kept count has reached k
	} cell_ctrl_t;

	// k register saturated to 1..KMAX
	function automatic kcnt_t eff_k(input kreg_t k);
		kcnt_t r;
		if (k == '0) begin
			r = kcnt_t'(1);
		end else if (int'(k) > KMAX) begin
			r = kcnt_t'(KMAX);
		end else begin
			r = kcnt_t'(k);
		end
		return r;
	endfunction

endpackage

// ===== src/tkns_cell.sv =====
// tkns_cell: one slot of the sorted insertion chain, holds a (distance, id) pair
// depends on tkns_pkg

module tkns_cell (
	input  logic                clk,
	input  tkns_pkg::cell_ctrl_t ctrl,
	input  logic                in_range,
	input  tkns_pkg::dist_t     new_dist,
	input  tkns_pkg::id_t       new_id,
	input  tkns_pkg::dist_t     prev_dist,
	input  tkns_pkg::id_t       prev_id,
	input  logic                prev_gt,
	input  tkns_pkg::dist_t     next_dist,
	input  tkns_pkg::id_t       next_id,
	output tkns_pkg::dist_t     kept_dist,
	output tkns_pkg::id_t       kept_id,
	output logic                gt
);

	tkns_pkg::dist_t dist_q;
	tkns_pkg::id_t   id_q;

	// new entry belongs at or before this slot; empty slots only take it below k
	assign gt = in_range ? (dist_q > new_dist) : !ctrl.full;

	// first slot past the new distance takes it, later slots the neighbor; shift takes next
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			dist_q <= next_dist;
			id_q   <= next_id;
		end else if (ctrl.insert && gt) begin
			if (prev_gt) begin
				dist_q <= prev_dist;
				id_q   <= prev_id;
			end else begin
				dist_q <= new_dist;
				id_q   <= new_id;
			end
		end
	end

	assign kept_dist = dist_q;
	assign kept_id   = id_q;

endmodule

// ===== src/top_k_nearest_selector_unit.sv =====
// Top-k nearest selector: an offer request is taken every cycle while input is not
// stalled and is inserted into a sorted chain of 16 cells. A finish request emits
// min(count, k) results (one if nothing is held), one per cycle while the output is
// not stalled, from the head of the chain through the result register; input is
// stalled until the last result is loaded. Reset clears the kept count and the state
// machine and sets k to 16; cell contents are not cleared.
// depends on tkns_pkg and tkns_cell

module top_k_nearest_selector_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	// request channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  tkns_pkg::dist_t        candidate_distance,
	input  tkns_pkg::id_t          candidate_id,
	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output tkns_pkg::dist_t        result_distance,
	output tkns_pkg::id_t          result_id,
	output tkns_pkg::rank_t        rank,
	output logic                   last,
	output logic                   empty_res,
	// k register write
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  tkns_pkg::kreg_t        k_results
);

	tkns_pkg::state_t state_q, state_d;
	tkns_pkg::cnt_t   count_q;
	tkns_pkg::kcnt_t  left_q;
	tkns_pkg::rank_t  rank_q;
	logic             empty_q;
	tkns_pkg::kreg_t  k_q;

	logic             out_valid_q;
	tkns_pkg::dist_t  res_dist_q;
	tkns_pkg::id_t    res_id_q;
	tkns_pkg::rank_t  res_rank_q;
	logic             res_last_q;
	logic             res_empty_q;

	tkns_pkg::kcnt_t  keff;
	logic             full;
	logic             in_take;
	logic             offer_take;
	logic             finish_take;
	logic             out_load;
	logic             emit_last;
	tkns_pkg::kcnt_t  n_emit;
	tkns_pkg::cell_ctrl_t ctrl;

	logic [tkns_pkg::CAPACITY-1:0]                      cell_gt;
	logic [tkns_pkg::CAPACITY-1:0][tkns_pkg::DIST_W-1:0] cell_dist;
	logic [tkns_pkg::CAPACITY-1:0][tkns_pkg::ID_W-1:0]   cell_id;

	// k register, writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= tkns_pkg::kreg_t'(16);
		end else if (cfg_valid && cfg_ready) begin
			k_q <= k_results;
		end
	end

	// request decode
	assign keff        = tkns_pkg::eff_k(k_q);
	assign full        = count_q >= tkns_pkg::cnt_t'(keff);
	assign in_stall    = (state_q == tkns_pkg::ST_EMIT);
	assign in_take     = in_valid && !in_stall;
	assign offer_take  = in_take && (command == tkns_pkg::CMD_OFFER);
	assign finish_take = in_take && (command == tkns_pkg::CMD_FINISH);
	assign n_emit      = (count_q < tkns_pkg::cnt_t'(keff)) ? tkns_pkg::kcnt_t'(count_q) : keff;

	// emission control
	assign out_load  = (state_q == tkns_pkg::ST_EMIT) && (!out_valid_q || !out_stall);
	assign emit_last = empty_q || (left_q == tkns_pkg::kcnt_t'(1));

	assign ctrl.insert = offer_take;
	assign ctrl.shift  = out_load && !empty_q;
	assign ctrl.full   = full;

	// sorted insertion chain
	for (genvar i = 0; i < tkns_pkg::CAPACITY; i++) begin : g_cell
		tkns_pkg::dist_t p_dist, n_dist;
		tkns_pkg::id_t   p_id, n_id;
		logic            p_gt;

		if (i == 0) begin : g_head
			assign p_dist = '0;
			assign p_id   = '0;
			assign p_gt   = 1'b0;
		end else begin : g_body
			assign p_dist = cell_dist[i-1];
			assign p_id   = cell_id[i-1];
			assign p_gt   = cell_gt[i-1];
		end

		if (i == tkns_pkg::CAPACITY - 1) begin : g_tail
			assign n_dist = cell_dist[i];
			assign n_id   = cell_id[i];
		end else begin : g_mid
			assign n_dist = cell_dist[i+1];
			assign n_id   = cell_id[i+1];
		end

		tkns_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.in_range  (count_q > tkns_pkg::cnt_t'(i)),
			.new_dist  (candidate_distance),
			.new_id    (candidate_id),
			.prev_dist (p_dist),
			.prev_id   (p_id),
			.prev_gt   (p_gt),
			.next_dist (n_dist),
			.next_id   (n_id),
			.kept_dist (cell_dist[i]),
			.kept_id   (cell_id[i]),
			.gt        (cell_gt[i])
		);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkns_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tkns_pkg::ST_IDLE: begin
				if (finish_take) begin
					state_d = tkns_pkg::ST_EMIT;
				end
			end
			tkns_pkg::ST_EMIT: begin
				if (out_load && emit_last) begin
					state_d = tkns_pkg::ST_IDLE;
				end
			end
			default: state_d = tkns_pkg::ST_IDLE;
		endcase
	end

	// kept count and emission counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			left_q  <= '0;
			rank_q  <= '0;
			empty_q <= 1'b0;
		end else if (finish_take) begin
			count_q <= '0;
			left_q  <= n_emit;
			rank_q  <= '0;
			empty_q <= (count_q == '0);
		end else if (offer_take && !full) begin
			count_q <= count_q + tkns_pkg::cnt_t'(1);
		end else if (out_load) begin
			left_q <= left_q - tkns_pkg::kcnt_t'(1);
			rank_q <= rank_q + tkns_pkg::rank_t'(1);
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload from the chain head
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_dist_q  <= empty_q ? '0 : tkns_pkg::dist_t'(cell_dist[0]);
			res_id_q    <= empty_q ? '0 : tkns_pkg::id_t'(cell_id[0]);
			res_rank_q  <= rank_q;
			res_last_q  <= emit_last;
			res_empty_q <= empty_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_distance = res_dist_q;
	assign result_id       = res_id_q;
	assign rank            = res_rank_q;
	assign last            = res_last_q;
	assign empty_res       = res_empty_q;

	// checks
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish_take |=> count_q == '0)
		else $error("kept count not cleared after finish");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tkns_pkg::cnt_t'(tkns_pkg::CAPACITY))
		else $error("kept count beyond capacity");

	a_emit_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tkns_pkg::ST_EMIT) && !empty_q |-> left_q != '0)
		else $error("emission running with nothing left");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_empty_q |-> res_last_q && (res_rank_q == '0))
		else $error("empty result not marked last at rank zero");

endmodule
